// ===== hw/rtl/dsbs_pkg.sv =====
package dsbs_pkg;

	localparam int MAX_LEGS      = 2;
	localparam int NAME_CAPACITY = 16;
	localparam int LEG_W         = $clog2(MAX_LEGS + 1);

	typedef enum logic [3:0] {
		EV_BEGIN        = 4'd0,
		EV_LINK_ADDED   = 4'd1,
		EV_CLIENT_ALLOC = 4'd2,
		EV_BOUND        = 4'd3,
		EV_STARTED      = 4'd4,
		EV_SETTINGS     = 4'd5,
		EV_CONFIGURED   = 4'd6,
		EV_UNCONFIGURED = 4'd7,
		EV_STOP         = 4'd8,
		EV_FAIL         = 4'd9,
		EV_STOPPED      = 4'd10,
		EV_RELEASED     = 4'd11,
		EV_DELETED      = 4'd12,
		EV_CLEANUP_FAIL = 4'd13,
		EV_RESTART      = 4'd14
	} event_t;

	typedef enum logic [1:0] {
		FAM_V4   = 2'd0,
		FAM_V6   = 2'd1,
		FAM_DUAL = 2'd2,
		FAM_BAD  = 2'd3
	} family_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_BUSY    = 3'd2,
		ST_PROTO   = 3'd3,
		ST_STALE   = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		AC_NONE        = 4'd0,
		AC_ADD         = 4'd1,
		AC_ALLOC       = 4'd2,
		AC_BIND        = 4'd3,
		AC_START       = 4'd4,
		AC_SETTINGS    = 4'd5,
		AC_CONFIGURE   = 4'd6,
		AC_UNCONFIGURE = 4'd7,
		AC_STOP        = 4'd8,
		AC_RELEASE     = 4'd9,
		AC_DELETE      = 4'd10,
		AC_UP          = 4'd11,
		AC_DOWN        = 4'd12
	} action_t;

	typedef enum logic [13:0] {
		PH_IDLE        = 14'b00000000000001,
		PH_ADDING      = 14'b00000000000010,
		PH_ALLOC       = 14'b00000000000100,
		PH_BINDING     = 14'b00000000001000,
		PH_STARTING    = 14'b00000000010000,
		PH_SETTINGS    = 14'b00000000100000,
		PH_CONFIGURING = 14'b00000001000000,
		PH_UP          = 14'b00000010000000,
		PH_UNCONFIG    = 14'b00000100000000,
		PH_STOPPING    = 14'b00001000000000,
		PH_RELEASING   = 14'b00010000000000,
		PH_DELETING    = 14'b00100000000000,
		PH_FAILED      = 14'b01000000000000,
		PH_BLOCKED     = 14'b10000000000000
	} phase_t;

	typedef struct packed {
		logic [3:0]  req_type;
		logic [1:0]  family;
		logic [4:0]  name_length;
		logic [8:0]  mux_id;
		logic [1:0]  leg;
		logic [31:0] pkt_hdl;
		logic [7:0]  error_code;
	} req_t;

	typedef struct packed {
		status_t     status;
		action_t     action;
		logic        action_leg;
		logic [31:0] action_handle;
		logic [3:0]  phase_now;
	} rsp_t;

	// numeric phase as reported on the result channel
	function automatic logic [3:0] phase_code(phase_t ph);
		logic [3:0] c;
		c = 4'd0;
		unique case (ph)
			PH_IDLE:        c = 4'd0;
			PH_ADDING:      c = 4'd1;
			PH_ALLOC:       c = 4'd2;
			PH_BINDING:     c = 4'd3;
			PH_STARTING:    c = 4'd4;
			PH_SETTINGS:    c = 4'd5;
			PH_CONFIGURING: c = 4'd6;
			PH_UP:          c = 4'd7;
			PH_UNCONFIG:    c = 4'd8;
			PH_STOPPING:    c = 4'd9;
			PH_RELEASING:   c = 4'd10;
			PH_DELETING:    c = 4'd11;
			PH_FAILED:      c = 4'd12;
			PH_BLOCKED:     c = 4'd13;
			default:        c = 4'd0;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/dsbs_req_if.sv =====
interface dsbs_req_if;
	logic           valid;
	logic           ready;
	dsbs_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dsbs_rsp_if.sv =====
interface dsbs_rsp_if;
	logic           valid;
	logic           ready;
	dsbs_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/data_session_bringup_sequencer.sv =====
// channel | dir | payload                                            | handshake
// req     | in  | event: type, family, name length, mux, leg, handle | valid/ready
// rsp     | out | status, action, action leg, action handle, phase   | valid/ready
//
// one request in, one result out; each request passes through the input
// register and then the result register
// a new request is taken every cycle unless a stalled result backs up the input register;
// the session state updates as the input register drains into the result register, so back-to-back requests see it
// a stalled result holds the result register and then the input register
// arst_n clears the phase, leg counters, held flags, error flag and handles
module data_session_bringup_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	dsbs_req_if.sink        req,
	dsbs_rsp_if.source      rsp
);
	import dsbs_pkg::*;

	// input register
	req_t             req_s1;
	logic             vld_s1;
	// result register
	rsp_t             rsp_s2;
	logic             vld_s2;

	// session state
	phase_t           phase_q;
	logic [LEG_W-1:0] leg_total_q;
	logic [LEG_W-1:0] leg_cursor_q;
	logic             link_held_q;
	logic             clients_held_q;
	logic             lcfg_held_q;
	logic             err_set_q;
	logic [31:0]      handles_q [MAX_LEGS];

	// next state
	phase_t           n_phase;
	logic [LEG_W-1:0] n_ltot;
	logic [LEG_W-1:0] n_cur;
	logic             n_link;
	logic             n_clients;
	logic             n_lcfg;
	logic             n_err;
	logic [31:0]      n_h [MAX_LEGS];

	status_t          st;
	action_t          act;
	logic             act_leg;
	logic [31:0]      act_hdl;
	logic             do_start;
	logic             do_adv;
	logic             leg_match;
	logic             leg_in_range;
	logic             adv;

	// input register drains when the result slot is free or being taken
	assign adv       = vld_s1 && (!vld_s2 || rsp.ready);
	assign req.ready = !vld_s1 || adv;

	// per-leg completion must name the expected leg inside the leg count
	assign leg_in_range = LEG_W'(req_s1.leg) < leg_total_q;
	assign leg_match    = (LEG_W'(req_s1.leg) == leg_cursor_q) && leg_in_range
		&& (req_s1.leg[1] == 1'b0);

	always_comb begin
		n_phase   = phase_q;
		n_ltot    = leg_total_q;
		n_cur     = leg_cursor_q;
		n_link    = link_held_q;
		n_clients = clients_held_q;
		n_lcfg    = lcfg_held_q;
		n_err     = err_set_q;
		for (int i = 0; i < MAX_LEGS; i++) begin
			n_h[i] = handles_q[i];
		end
		st       = ST_OK;
		act      = AC_NONE;
		act_leg  = 1'b0;
		act_hdl  = '0;
		do_start = 1'b0;
		do_adv   = 1'b0;

		unique case (req_s1.req_type)
			EV_BEGIN: begin
				if (req_s1.family == FAM_BAD) begin
					st = ST_INVALID;
				end else if (phase_q != PH_IDLE && phase_q != PH_FAILED) begin
					st = ST_BUSY;
				end else begin
					n_ltot    = (req_s1.family == FAM_DUAL) ? LEG_W'(2) : LEG_W'(1);
					n_cur     = '0;
					n_link    = 1'b0;
					n_clients = 1'b0;
					n_lcfg    = 1'b0;
					n_err     = 1'b0;
					for (int i = 0; i < MAX_LEGS; i++) begin
						n_h[i] = '0;
					end
					n_phase = PH_ADDING;
					act     = AC_ADD;
				end
			end
			EV_LINK_ADDED: begin
				// mux must fit in a byte and be nonzero; name needs room for its end mark
				if (phase_q != PH_ADDING || req_s1.mux_id[8] || req_s1.mux_id[7:0] == 8'd0
					|| req_s1.name_length == 5'd0
					|| 6'(req_s1.name_length) >= 6'(NAME_CAPACITY)) begin
					st = ST_INVALID;
				end else begin
					n_link  = 1'b1;
					n_cur   = '0;
					n_phase = PH_ALLOC;
					act     = AC_ALLOC;
				end
			end
			EV_CLIENT_ALLOC: begin
				if (phase_q != PH_ALLOC || !leg_match) begin
					st = ST_PROTO;
				end else begin
					n_clients = 1'b1;
					n_cur     = leg_cursor_q + LEG_W'(1);
					if (n_cur < leg_total_q) begin
						act     = AC_ALLOC;
						act_leg = n_cur[0];
					end else begin
						n_cur   = '0;
						n_phase = PH_BINDING;
						act     = AC_BIND;
					end
				end
			end
			EV_BOUND: begin
				if (phase_q != PH_BINDING || !leg_match) begin
					st = ST_PROTO;
				end else begin
					n_cur = leg_cursor_q + LEG_W'(1);
					if (n_cur < leg_total_q) begin
						act     = AC_BIND;
						act_leg = n_cur[0];
					end else begin
						n_cur   = '0;
						n_phase = PH_STARTING;
						act     = AC_START;
					end
				end
			end
			EV_STARTED: begin
				if (req_s1.pkt_hdl == 32'd0 || phase_q != PH_STARTING || !leg_match
					|| handles_q[req_s1.leg[0]] != 32'd0) begin
					st = ST_PROTO;
				end else begin
					n_h[req_s1.leg[0]] = req_s1.pkt_hdl;
					n_cur = leg_cursor_q + LEG_W'(1);
					if (n_cur < leg_total_q) begin
						act     = AC_START;
						act_leg = n_cur[0];
					end else begin
						n_cur   = '0;
						n_phase = PH_SETTINGS;
						act     = AC_SETTINGS;
					end
				end
			end
			EV_SETTINGS: begin
				if (phase_q != PH_SETTINGS || !leg_match) begin
					st = ST_PROTO;
				end else begin
					n_cur = leg_cursor_q + LEG_W'(1);
					if (n_cur < leg_total_q) begin
						act     = AC_SETTINGS;
						act_leg = n_cur[0];
					end else begin
						// cursor left at the leg count
						n_phase = PH_CONFIGURING;
						act     = AC_CONFIGURE;
					end
				end
			end
			EV_CONFIGURED: begin
				if (phase_q != PH_CONFIGURING) begin
					st = ST_PROTO;
				end else begin
					n_lcfg  = 1'b1;
					n_phase = PH_UP;
					act     = AC_UP;
				end
			end
			EV_UNCONFIGURED: begin
				if (phase_q != PH_UNCONFIG) begin
					st = ST_PROTO;
				end else begin
					n_lcfg = 1'b0;
					do_adv = 1'b1;
				end
			end
			EV_STOP: begin
				if (phase_q != PH_UP) begin
					st = ST_PROTO;
				end else begin
					n_err    = 1'b0;
					do_start = 1'b1;
				end
			end
			EV_FAIL: begin
				if (req_s1.error_code == 8'd0 || phase_q == PH_IDLE
					|| phase_q == PH_FAILED || phase_q == PH_BLOCKED) begin
					st = ST_INVALID;
				end else begin
					n_err = 1'b1;
					// a half-applied configuration still needs undoing
					if (phase_q == PH_CONFIGURING) begin
						n_lcfg = 1'b1;
					end
					do_start = 1'b1;
				end
			end
			EV_STOPPED: begin
				if (phase_q != PH_STOPPING || !leg_in_range || req_s1.leg[1]
					|| req_s1.pkt_hdl == 32'd0
					|| handles_q[req_s1.leg[0]] != req_s1.pkt_hdl) begin
					st = ST_STALE;
				end else begin
					n_h[req_s1.leg[0]] = '0;
					do_adv = 1'b1;
				end
			end
			EV_RELEASED: begin
				if (phase_q != PH_RELEASING) begin
					st = ST_PROTO;
				end else begin
					n_clients = 1'b0;
					do_adv    = 1'b1;
				end
			end
			EV_DELETED: begin
				if (phase_q != PH_DELETING) begin
					st = ST_PROTO;
				end else begin
					n_link = 1'b0;
					do_adv = 1'b1;
				end
			end
			EV_CLEANUP_FAIL: begin
				if (req_s1.error_code == 8'd0 || !(phase_q == PH_UNCONFIG
					|| phase_q == PH_STOPPING || phase_q == PH_RELEASING
					|| phase_q == PH_DELETING)) begin
					st = ST_INVALID;
				end else begin
					n_phase = PH_BLOCKED;
				end
			end
			EV_RESTART: begin
				if (phase_q == PH_IDLE) begin
					st = ST_INVALID;
				end else begin
					// modem gone: clients and packet handles are already lost
					n_err     = 1'b1;
					n_clients = 1'b0;
					for (int i = 0; i < MAX_LEGS; i++) begin
						n_h[i] = '0;
					end
					if (lcfg_held_q) begin
						n_phase = PH_UNCONFIG;
						act     = AC_UNCONFIGURE;
					end else if (link_held_q) begin
						n_phase = PH_DELETING;
						act     = AC_DELETE;
					end else begin
						n_phase = PH_FAILED;
						act     = AC_DOWN;
					end
				end
			end
			default: begin
				st = ST_INVALID;
			end
		endcase

		// cleanup entry: undo local configuration first
		if (do_start) begin
			if (n_lcfg) begin
				n_phase = PH_UNCONFIG;
				act     = AC_UNCONFIGURE;
			end else begin
				do_adv = 1'b1;
			end
		end

		// next cleanup step: stop legs in order, release clients, delete link, then go down
		if (do_adv) begin
			if (n_ltot != '0 && n_h[0] != 32'd0) begin
				n_phase = PH_STOPPING;
				act     = AC_STOP;
				act_leg = 1'b0;
				act_hdl = n_h[0];
			end else if (n_ltot > LEG_W'(1) && n_h[1] != 32'd0) begin
				n_phase = PH_STOPPING;
				act     = AC_STOP;
				act_leg = 1'b1;
				act_hdl = n_h[1];
			end else if (n_clients) begin
				n_phase = PH_RELEASING;
				act     = AC_RELEASE;
			end else if (n_link) begin
				n_phase = PH_DELETING;
				act     = AC_DELETE;
			end else begin
				n_phase = n_err ? PH_FAILED : PH_IDLE;
				act     = AC_DOWN;
			end
		end

		// rejected request: no operation, state untouched
		if (st != ST_OK) begin
			act     = AC_NONE;
			act_leg = 1'b0;
			act_hdl = '0;
			n_phase = phase_q;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (rsp.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2.status        <= st;
			rsp_s2.action        <= act;
			rsp_s2.action_leg    <= act_leg;
			rsp_s2.action_handle <= act_hdl;
			rsp_s2.phase_now     <= phase_code(n_phase);
		end
	end

	// session state commits only for accepted requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			leg_total_q    <= '0;
			leg_cursor_q   <= '0;
			link_held_q    <= 1'b0;
			clients_held_q <= 1'b0;
			lcfg_held_q    <= 1'b0;
			err_set_q      <= 1'b0;
			for (int i = 0; i < MAX_LEGS; i++) begin
				handles_q[i] <= '0;
			end
		end else if (adv && st == ST_OK) begin
			phase_q        <= n_phase;
			leg_total_q    <= n_ltot;
			leg_cursor_q   <= n_cur;
			link_held_q    <= n_link;
			clients_held_q <= n_clients;
			lcfg_held_q    <= n_lcfg;
			err_set_q      <= n_err;
			for (int i = 0; i < MAX_LEGS; i++) begin
				handles_q[i] <= n_h[i];
			end
		end
	end

	assign rsp.valid = vld_s2;
	assign rsp.data  = rsp_s2;

endmodule

// ===== hw/rtl/dsbs_checker.sv =====
module dsbs_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input dsbs_pkg::rsp_t rsp_data
);
	import dsbs_pkg::*;

	// stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// stalled result keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("result changed while stalled");

	// rejected request asks for no operation
	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |->
		rsp_data.action == AC_NONE && !rsp_data.action_leg
		&& rsp_data.action_handle == 32'd0)
		else $error("rejected request carries an operation");

	// a packet handle goes out only with a stop-leg operation in the stopping phase
	a_handle_stop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.action_handle != 32'd0 |->
		rsp_data.action == AC_STOP && rsp_data.phase_now == phase_code(PH_STOPPING))
		else $error("handle without stop-leg operation");

endmodule

bind data_session_bringup_sequencer dsbs_checker u_dsbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
